// ===== src/mpe_pkg.sv =====
// Shared widths, register indexes, item types and saturation helper for the pixel engine.
`default_nettype none
package mpe_pkg;
	localparam int COORD_W   = 32;
	localparam int SPAN_W    = 31;
	localparam int DIM_W     = 13;
	localparam int PIX_W     = 12;
	localparam int ITER_W    = 16;
	localparam int GRAY_W    = 8;
	localparam int COLOR_W   = 32;
	localparam int FRAC_BITS = 27;
	localparam int MAX_DIM   = 4096;
	localparam int PROD_W    = PIX_W + SPAN_W;
	localparam int WIDE_W    = 2 * COORD_W + 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_X_MIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_SPAN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SPAN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 3'd6;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_min;
		logic [SPAN_W-1:0]         x_span;
		logic signed [COORD_W-1:0] y_min;
		logic [SPAN_W-1:0]         y_span;
		logic [DIM_W-1:0]          frame_cols;
		logic [DIM_W-1:0]          frame_rows;
		logic [ITER_W-1:0]         max_iter;
	} mpe_cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]          col;
		logic [PIX_W-1:0]          row;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} mpe_point_t;

	// Clamp a wide signed value into the signed coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
		lo = -WIDE_W'(64'sd1 <<< (COORD_W - 1));
		if (v > hi) begin
			sat_coord = hi[COORD_W-1:0];
		end else if (v < lo) begin
			sat_coord = lo[COORD_W-1:0];
		end else begin
			sat_coord = v[COORD_W-1:0];
		end
	endfunction
endpackage
`default_nettype wire

// ===== src/mpe_if.sv =====
// Valid/ready channel interfaces for pixel items and result items.
`default_nettype none
interface mpe_pix_if;
	logic                    valid;
	logic                    ready;
	logic [mpe_pkg::PIX_W-1:0] pixel_col;
	logic [mpe_pkg::PIX_W-1:0] pixel_row;
	modport source (output valid, pixel_col, pixel_row, input ready);
	modport sink (input valid, pixel_col, pixel_row, output ready);
endinterface

interface mpe_res_if;
	logic                      valid;
	logic                      ready;
	logic [mpe_pkg::PIX_W-1:0]   out_col;
	logic [mpe_pkg::PIX_W-1:0]   out_row;
	logic [mpe_pkg::ITER_W-1:0]  iter_count;
	logic [mpe_pkg::GRAY_W-1:0]  gray_level;
	logic [mpe_pkg::COLOR_W-1:0] pixel_color;
	modport source (output valid, out_col, out_row, iter_count, gray_level, pixel_color,
		input ready);
	modport sink (input valid, out_col, out_row, iter_count, gray_level, pixel_color,
		output ready);
endinterface
`default_nettype wire

// ===== src/mpe_front.sv =====
// Front end: accept a pixel item and map it to a complex point with a serial divider.
`default_nettype none
module mpe_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	mpe_pix_if.sink                 pix,
	input  wire mpe_pkg::mpe_cfg_t  cfg,
	output mpe_pkg::mpe_point_t     push_data,
	output logic                    push_valid,
	input  wire logic               push_full
);
	import mpe_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_PUSH = 2'd3;
	localparam int CNT_W = $clog2(PROD_W);
	localparam int REM_W = DIM_W + 1;

	logic [1:0]          state_q;
	logic [PIX_W-1:0]    col_q, row_q;
	logic [PROD_W-1:0]   num_x_q, num_y_q;
	logic [DIM_W-1:0]    rem_x_q, rem_y_q;
	logic [DIM_W-1:0]    dx_q, dy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIM_W-1:0]    dx_c, dy_c;
	logic [REM_W-1:0]    trial_x, trial_y;
	logic                qx, qy;
	logic signed [WIDE_W-1:0] sum_x, sum_y;

	// Clamp the pixel counts into one .. MAX_DIM
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		if (d == '0) begin
			clamp_dim = DIM_W'(1);
		end else if (d > DIM_W'(MAX_DIM)) begin
			clamp_dim = DIM_W'(MAX_DIM);
		end else begin
			clamp_dim = d;
		end
	endfunction

	assign dx_c = clamp_dim(cfg.frame_cols);
	assign dy_c = clamp_dim(cfg.frame_rows);

	// One restoring quotient bit per cycle for each axis
	assign trial_x = {rem_x_q, num_x_q[PROD_W-1]};
	assign trial_y = {rem_y_q, num_y_q[PROD_W-1]};
	assign qx = trial_x >= {1'b0, dx_q};
	assign qy = trial_y >= {1'b0, dy_q};

	// Add the edge to the quotient and saturate
	assign sum_x = WIDE_W'(cfg.x_min) + $signed({{(WIDE_W-PROD_W){1'b0}}, num_x_q});
	assign sum_y = WIDE_W'(cfg.y_min) + $signed({{(WIDE_W-PROD_W){1'b0}}, num_y_q});

	assign pix.ready = (state_q == ST_IDLE);
	assign push_valid = (state_q == ST_PUSH);
	assign push_data.col = col_q;
	assign push_data.row = row_q;
	assign push_data.cx = sat_coord(sum_x);
	assign push_data.cy = sat_coord(sum_y);

	// Sequence accept, multiply, divide and hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pix.valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(PROD_W - 1)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!push_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pix.valid) begin
			col_q <= pix.pixel_col;
			row_q <= pix.pixel_row;
		end
		if (state_q == ST_MUL) begin
			num_x_q <= PROD_W'(col_q) * PROD_W'(cfg.x_span);
			num_y_q <= PROD_W'(row_q) * PROD_W'(cfg.y_span);
			rem_x_q <= '0;
			rem_y_q <= '0;
			dx_q <= dx_c;
			dy_q <= dy_c;
		end
		if (state_q == ST_DIV) begin
			rem_x_q <= qx ? DIM_W'(trial_x - {1'b0, dx_q}) : trial_x[DIM_W-1:0];
			rem_y_q <= qy ? DIM_W'(trial_y - {1'b0, dy_q}) : trial_y[DIM_W-1:0];
			num_x_q <= {num_x_q[PROD_W-2:0], qx};
			num_y_q <= {num_y_q[PROD_W-2:0], qy};
		end
	end
endmodule
`default_nettype wire

// ===== src/mpe_fifo.sv =====
// Two-entry queue of mapped points between front and back.
`default_nettype none
module mpe_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire mpe_pkg::mpe_point_t push_data,
	output logic                     full,
	input  wire logic                pop,
	output mpe_pkg::mpe_point_t      pop_data,
	output logic                     empty
);
	import mpe_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	mpe_point_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   fill_q;
	logic             do_push, do_pop;

	assign full = (fill_q == (PTR_W+1)'(DEPTH));
	assign empty = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (PTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (PTR_W+1)'(1);
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

// ===== src/mpe_back.sv =====
// Back end: escape-time iteration, gray scaling and the result register.
`default_nettype none
module mpe_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mpe_pkg::mpe_cfg_t   cfg,
	input  wire mpe_pkg::mpe_point_t pop_data,
	input  wire logic                empty,
	output logic                     pop,
	mpe_res_if.source                res
);
	import mpe_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam int NUM_W = ITER_W + GRAY_W;
	localparam int DCNT_W = $clog2(NUM_W);
	localparam int SQ_W = 2 * COORD_W;
	localparam logic [SQ_W:0] BOUND = (SQ_W+1)'(1) << (2 * FRAC_BITS + 2);

	logic [2:0]                state_q;
	mpe_point_t                pt_q;
	logic signed [COORD_W-1:0] zx_q, zy_q;
	logic [ITER_W-1:0]         count_q, limit_q;
	logic [SQ_W-1:0]           xx_s1, yy_s1;
	logic signed [SQ_W-1:0]    xy_s1;
	logic [NUM_W-1:0]          num_q;
	logic [ITER_W-1:0]         rem_q;
	logic [DCNT_W-1:0]         dcnt_q;
	logic                      res_valid_q;
	logic [GRAY_W-1:0]         gray_c;
	logic [COORD_W-1:0]        mag_x, mag_y;
	logic [SQ_W:0]             mag_sum;
	logic signed [WIDE_W-1:0]  re_c, im_c;
	logic [ITER_W:0]           trial;
	logic                      qbit;
	logic                      load_out;
	logic [NUM_W-1:0]          scaled;

	assign mag_x = zx_q[COORD_W-1] ? COORD_W'(-zx_q) : COORD_W'(zx_q);
	assign mag_y = zy_q[COORD_W-1] ? COORD_W'(-zy_q) : COORD_W'(zy_q);
	assign mag_sum = {1'b0, xx_s1} + {1'b0, yy_s1};

	// Next z: floor shift of the exact products, plus c
	assign re_c = (($signed({2'b00, xx_s1}) - $signed({2'b00, yy_s1})) >>> FRAC_BITS)
		+ WIDE_W'(pt_q.cx);
	assign im_c = ((WIDE_W'(xy_s1) <<< 1) >>> FRAC_BITS) + WIDE_W'(pt_q.cy);

	// Gray divider step
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign qbit = trial >= {1'b0, limit_q};
	assign scaled = (NUM_W'(count_q) << GRAY_W) - NUM_W'(count_q);
	assign gray_c = (limit_q == '0) ? '0 : num_q[GRAY_W-1:0];

	assign pop = (state_q == ST_IDLE) && !empty;
	assign load_out = (state_q == ST_OUT) && (!res_valid_q || res.ready);
	assign res.valid = res_valid_q;

	// Sequence the iteration loop and output hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= (count_q >= limit_q) ? ST_DIV : ST_UPD;
				end
				ST_UPD: begin
					state_q <= (mag_sum > BOUND) ? ST_DIV : ST_MUL;
				end
				ST_DIV: begin
					if (dcnt_q == DCNT_W'(NUM_W - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			pt_q <= pop_data;
			zx_q <= pop_data.cx;
			zy_q <= pop_data.cy;
			count_q <= '0;
			limit_q <= cfg.max_iter;
		end
		if (state_q == ST_MUL) begin
			xx_s1 <= SQ_W'(mag_x) * SQ_W'(mag_x);
			yy_s1 <= SQ_W'(mag_y) * SQ_W'(mag_y);
			xy_s1 <= SQ_W'(zx_q) * SQ_W'(zy_q);
		end
		if ((state_q == ST_MUL && count_q >= limit_q)
				|| (state_q == ST_UPD && mag_sum > BOUND)) begin
			num_q <= scaled;
			rem_q <= '0;
			dcnt_q <= '0;
		end else if (state_q == ST_UPD) begin
			zx_q <= sat_coord(re_c);
			zy_q <= sat_coord(im_c);
			count_q <= count_q + ITER_W'(1);
		end
		if (state_q == ST_DIV) begin
			rem_q <= qbit ? ITER_W'(trial - {1'b0, limit_q}) : trial[ITER_W-1:0];
			num_q <= {num_q[NUM_W-2:0], qbit};
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
		if (load_out) begin
			res.out_col <= pt_q.col;
			res.out_row <= pt_q.row;
			res.iter_count <= count_q;
			res.gray_level <= gray_c;
			res.pixel_color <= {8'h00, gray_c, gray_c, gray_c};
		end
	end
endmodule
`default_nettype wire

// ===== src/mandelbrot_pixel_engine.sv =====
// Top level: configuration registers, front end, point queue and iteration back end.
//
//  channel  dir  handshake      payload
//  pix      in   valid/ready    pixel_col, pixel_row
//  res      out  valid/ready    out_col, out_row, iter_count, gray_level, pixel_color
//  cfg      in   cfg_we         cfg_index, cfg_data
//
// Front end: per item a product, a 43-step serial divide and a hand-off that waits
// while the queue is full. Back end: each iteration has a multiply stage and an update
// stage; the loop ends at the limit or on escape, and then the 24-step gray divide runs.
// A two-entry queue lets the front map the next points while the back iterates.
// Reset loads the default view; a stalled result holds the back end in its output state.
`default_nettype none
module mandelbrot_pixel_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	mpe_pix_if.sink                            pix,
	mpe_res_if.source                          res,
	input  wire logic                          cfg_we,
	input  wire logic [mpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mpe_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mpe_pkg::*;

	mpe_cfg_t   cfg_q;
	mpe_point_t push_data, pop_data;
	logic       push_valid, full, pop, empty;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_min <= -32'sd536870912;
			cfg_q.x_span <= 31'd1073741824;
			cfg_q.y_min <= -32'sd536870912;
			cfg_q.y_span <= 31'd1073741824;
			cfg_q.frame_cols <= 13'd500;
			cfg_q.frame_rows <= 13'd500;
			cfg_q.max_iter <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_MIN:      cfg_q.x_min <= cfg_data[COORD_W-1:0];
				REG_X_SPAN:     cfg_q.x_span <= cfg_data[SPAN_W-1:0];
				REG_Y_MIN:      cfg_q.y_min <= cfg_data[COORD_W-1:0];
				REG_Y_SPAN:     cfg_q.y_span <= cfg_data[SPAN_W-1:0];
				REG_FRAME_COLS: cfg_q.frame_cols <= cfg_data[DIM_W-1:0];
				REG_FRAME_ROWS: cfg_q.frame_rows <= cfg_data[DIM_W-1:0];
				REG_MAX_ITER:   cfg_q.max_iter <= cfg_data[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	mpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.cfg        (cfg_q),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_full  (full)
	);

	mpe_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	mpe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pop_data (pop_data),
		.empty    (empty),
		.pop      (pop),
		.res      (res)
	);
endmodule
`default_nettype wire
